// ----- design/tcpwm_pkg.sv -----
package tcpwm_pkg;

    // channel and counter geometry
    localparam int NUM_CH   = 3;
    localparam int CH_W     = 2;
    localparam int COUNT_W  = 24;
    localparam int MATCH_W  = COUNT_W + 1;
    localparam int PCT_W    = 8;
    localparam int PCT_LO_W = 7;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_DUTY = 1'b1;

    // reset values
    localparam logic [COUNT_W-1:0] DEFAULT_PERIOD = COUNT_W'(12000);
    localparam logic [MATCH_W-1:0] RESET_MATCH    = MATCH_W'(6000);
    localparam logic [PCT_W-1:0]   PCT_FULL       = PCT_W'(100);

    // period / 100 by reciprocal: q = (p * 21474837) >> 31, exact for 24-bit p
    localparam int RECIP_P_W     = 25;
    localparam int RECIP_P_SHIFT = 31;
    localparam logic [RECIP_P_W-1:0] RECIP_P = RECIP_P_W'(21474837);
    localparam int PQ_W          = 18;
    localparam int PR_W          = 7;
    localparam logic [PQ_W-1:0] PQ_RESET = PQ_W'(12000 / 100);
    localparam logic [PR_W-1:0] PR_RESET = PR_W'(12000 % 100);

    // small value / 100 by reciprocal: q = (x * 5243) >> 19, exact for x < 10000
    localparam int RECIP_S_W     = 13;
    localparam int RECIP_S_SHIFT = 19;
    localparam logic [RECIP_S_W-1:0] RECIP_S = RECIP_S_W'(5243);
    localparam int LO_W          = 2 * PCT_LO_W;
    localparam int LO_PROD_W     = LO_W + RECIP_S_W;
    localparam int LO_Q_W        = LO_PROD_W - RECIP_S_SHIFT;

    typedef logic [MATCH_W-1:0] t_match;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ----- design/three_channel_percent_pwm_top.sv -----
// throughput: one item per cycle, ticks and duty writes alike, set by the single
//   pass from the input register to the result register, while results are taken
// a period write holds off input items while period/100 and period%100 are rebuilt
// reset (synchronous, active low): count 0, all matches 6000, channel levels high, period 12000
module three_channel_percent_pwm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [tcpwm_pkg::CH_W-1:0]    i_channel,
    input  logic [tcpwm_pkg::PCT_W-1:0]   i_duty_percent,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcpwm_pkg::NUM_CH-1:0]  o_pwm_out,
    output logic                          o_period_end,
    output logic                          o_write_ignored,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcpwm_pkg::COUNT_W-1:0] i_cfg_period_ticks
);
    import tcpwm_pkg::*;

    // input register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [CH_W-1:0]   r_in_channel;
    logic [PCT_W-1:0]  r_in_duty;

    // result register
    logic              r_out_valid;
    logic [NUM_CH-1:0] r_pwm_out;
    logic              r_period_end;
    logic              r_write_ignored;

    // period and its split into quotient and remainder by 100
    t_count            r_period;
    logic [PQ_W-1:0]   r_pq;
    logic [PR_W-1:0]   r_pr;
    logic [1:0]        r_cfg_busy;

    // timer state
    t_count            r_count;
    t_match            r_reload [NUM_CH];
    t_match            r_active [NUM_CH];
    logic [NUM_CH-1:0] r_level;

    // pending duty conversion, finished in the cycle after the duty item
    logic              r_pend_valid;
    logic [CH_W-1:0]   r_pend_ch;
    t_count            r_pend_hi;
    logic [LO_W-1:0]   r_pend_lo;
    logic              r_pend_zero;

    // next values
    t_count            n_count;
    t_match            n_reload [NUM_CH];
    t_match            n_active [NUM_CH];
    logic [NUM_CH-1:0] n_level;
    logic              n_pend_valid;

    logic                          proc;
    logic                          is_duty;
    logic                          ch_ok;
    logic                          pct_full;
    logic                          pct_zero;
    logic                          divided;
    t_match                        direct_match;
    logic [MATCH_W-1:0]            prod_hi;
    t_count                        hi_part;
    logic [LO_W-1:0]               lo_part;
    logic [LO_PROD_W-1:0]          lo_prod;
    t_match                        pend_match;
    t_count                        next_count;
    logic                          wrap;
    logic [COUNT_W+RECIP_P_W-1:0]  pq_prod;
    logic [MATCH_W-1:0]            pr_prod;
    t_count                        pr_diff;

    // handshake
    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (!r_in_valid || proc) && (r_cfg_busy == 2'b00);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_pwm_out       = r_pwm_out;
    assign o_period_end    = r_period_end;
    assign o_write_ignored = r_write_ignored;

    // item decode
    assign is_duty  = (r_in_cmd == CMD_DUTY);
    assign ch_ok    = (r_in_channel < CH_W'(NUM_CH));
    assign pct_full = (r_in_duty >= PCT_FULL);
    assign pct_zero = (r_in_duty == '0);
    assign divided  = !pct_full && !pct_zero;

    // full duty reload of 1, or never-matching reload (period + 1) for zero duty
    assign direct_match = pct_full ? MATCH_W'(1) : ({1'b0, r_period} + MATCH_W'(1));

    // first half of the conversion: period - (period/100)*pct and (period%100)*pct
    assign prod_hi = MATCH_W'(r_pq) * MATCH_W'(r_in_duty[PCT_LO_W-1:0]);
    assign hi_part = r_period - prod_hi[COUNT_W-1:0];
    assign lo_part = LO_W'(r_pr) * LO_W'(r_in_duty[PCT_LO_W-1:0]);

    // second half: subtract ((period%100)*pct)/100
    assign lo_prod    = LO_PROD_W'(r_pend_lo) * LO_PROD_W'(RECIP_S);
    assign pend_match = {1'b0, r_pend_hi} - MATCH_W'(lo_prod[RECIP_S_SHIFT +: LO_Q_W]);

    // counter advance
    assign next_count = r_count + COUNT_W'(1);
    assign wrap       = (next_count >= r_period) || (next_count == '0);

    // period split, two registered steps
    assign pq_prod = (COUNT_W+RECIP_P_W)'(r_period) * (COUNT_W+RECIP_P_W)'(RECIP_P);
    assign pr_prod = MATCH_W'(r_pq) * MATCH_W'(100);
    assign pr_diff = r_period - pr_prod[COUNT_W-1:0];

    // next timer state
    always_comb begin
        n_count      = r_count;
        n_level      = r_level;
        n_pend_valid = proc && is_duty && ch_ok && divided;
        for (int i = 0; i < NUM_CH; i++) begin
            n_active[i] = r_active[i];
            n_reload[i] = r_reload[i];
            if (r_pend_valid && (r_pend_ch == CH_W'(i))) begin
                n_reload[i] = pend_match;
            end
            if (proc && is_duty && ch_ok && !divided && (r_in_channel == CH_W'(i))) begin
                n_reload[i] = direct_match;
            end
        end
        if (proc && !is_duty) begin
            if (wrap) begin
                n_count = '0;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (r_pend_valid && (r_pend_ch == CH_W'(i))) begin
                        // conversion still in flight: its match is zero only for a zero period
                        n_active[i] = pend_match;
                        n_level[i]  = r_pend_zero;
                    end else begin
                        n_active[i] = r_reload[i];
                        n_level[i]  = (r_reload[i] == '0);
                    end
                end
            end else begin
                n_count = next_count;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (r_active[i] == {1'b0, next_count}) begin
                        n_level[i] = 1'b1;
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_cmd     <= i_cmd;
            r_in_channel <= i_channel;
            r_in_duty    <= i_duty_percent;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc) begin
            r_pwm_out       <= n_level;
            r_period_end    <= !is_duty && wrap;
            r_write_ignored <= is_duty && !ch_ok;
        end
    end

    // period register and its split by 100
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= DEFAULT_PERIOD;
            r_pq       <= PQ_RESET;
            r_pr       <= PR_RESET;
            r_cfg_busy <= 2'b00;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_period   <= i_cfg_period_ticks;
                r_cfg_busy <= 2'b01;
            end else begin
                r_cfg_busy <= {r_cfg_busy[0], 1'b0};
            end
            if (r_cfg_busy[0]) begin
                r_pq <= pq_prod[RECIP_P_SHIFT +: PQ_W];
            end
            if (r_cfg_busy[1]) begin
                r_pr <= pr_diff[PR_W-1:0];
            end
        end
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_level      <= '1;
            r_pend_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_reload[i] <= RESET_MATCH;
                r_active[i] <= RESET_MATCH;
            end
        end else begin
            r_count      <= n_count;
            r_level      <= n_level;
            r_pend_valid <= n_pend_valid;
            for (int i = 0; i < NUM_CH; i++) begin
                r_reload[i] <= n_reload[i];
                r_active[i] <= n_active[i];
            end
        end
    end

    // pending conversion payload
    always_ff @(posedge i_clk) begin
        if (n_pend_valid) begin
            r_pend_ch   <= r_in_channel;
            r_pend_hi   <= hi_part;
            r_pend_lo   <= lo_part;
            r_pend_zero <= (r_period == '0);
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tcpwm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_EDGES = 4;
    localparam int RANDOM_ITEMS = 1250;
    localparam t_count MAX_PERIOD = t_count'(24'hFFFFFE);
    localparam t_count MIN_PERIOD = t_count'(2);

    typedef struct packed {
        logic [NUM_CH-1:0] pwm_out;
        logic              period_end;
        logic              write_ignored;
    } t_pwm_result;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    // dut ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_cmd = CMD_TICK;
    logic [CH_W-1:0]      i_channel = '0;
    logic [PCT_W-1:0]     i_duty_percent = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [NUM_CH-1:0]    o_pwm_out;
    logic                 o_period_end;
    logic                 o_write_ignored;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_period_ticks = DEFAULT_PERIOD;

    // timer model state
    t_count            model_period;
    t_count            model_count;
    t_match            model_reload [NUM_CH];
    t_match            model_active [NUM_CH];
    logic [NUM_CH-1:0] model_levels;

    t_pwm_result expected_results [$];
    t_pwm_result head_result;

    int errors = 0;
    int checked_count = 0;
    int cycle_count = 0;
    int phase_count = 0;
    int burst_left = 0;
    int gap_max = 0;
    int rx_left = 0;
    int rx_tick = 0;
    t_rx_mode rx_mode = RX_ALWAYS;

    three_channel_percent_pwm_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_channel          (i_channel),
        .i_duty_percent     (i_duty_percent),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pwm_out          (o_pwm_out),
        .o_period_end       (o_period_end),
        .o_write_ignored    (o_write_ignored),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_period_ticks (i_cfg_period_ticks)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // percent to match value, using the period current at the write
    function automatic t_match duty_match(input logic [PCT_W-1:0] pct, input t_count per);
        longint unsigned prod;
        prod = longint'(per) * longint'(pct);
        if (pct >= PCT_FULL)
            return t_match'(1);
        if (pct == '0)
            return t_match'(per) + t_match'(1);
        return t_match'(per) - t_match'(prod / PCT_FULL);
    endfunction

    function automatic void reset_timer_model();
        model_period = DEFAULT_PERIOD;
        model_count  = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            model_reload[i] = RESET_MATCH;
            model_active[i] = RESET_MATCH;
        end
        model_levels = '1;
    endfunction

    // one item through the timer model
    function automatic t_pwm_result pwm_timer_step(input logic cmd, input logic [CH_W-1:0] ch,
                                                   input logic [PCT_W-1:0] pct);
        t_pwm_result res;
        t_count nxt;
        res.period_end    = 1'b0;
        res.write_ignored = 1'b0;
        if (cmd == CMD_DUTY) begin
            if (ch < NUM_CH)
                model_reload[ch] = duty_match(pct, model_period);
            else
                res.write_ignored = 1'b1;
        end else begin
            nxt = model_count + t_count'(1);
            // wrap: clear outputs and load the new matches
            if (nxt >= model_period || nxt == '0) begin
                model_count  = '0;
                model_levels = '0;
                for (int i = 0; i < NUM_CH; i++)
                    model_active[i] = model_reload[i];
                res.period_end = 1'b1;
            end else begin
                model_count = nxt;
            end
            for (int i = 0; i < NUM_CH; i++) begin
                if (model_active[i] == t_match'(model_count))
                    model_levels[i] = 1'b1;
            end
        end
        res.pwm_out = model_levels;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with none expected: pwm_out=%b period_end=%b",
                       o_pwm_out, o_period_end);
                errors++;
            end else begin
                head_result = expected_results.pop_front();
                checked_count++;
                if (o_pwm_out !== head_result.pwm_out) begin
                    $error("pwm_out: expected %b, actual %b", head_result.pwm_out, o_pwm_out);
                    errors++;
                end
                if (o_period_end !== head_result.period_end) begin
                    $error("period_end: expected %b, actual %b",
                           head_result.period_end, o_period_end);
                    errors++;
                end
                if (o_write_ignored !== head_result.write_ignored) begin
                    $error("write_ignored: expected %b, actual %b",
                           head_result.write_ignored, o_write_ignored);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS: i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: i_out_ready <= (rx_tick % 4) != 3;
            default:   i_out_ready <= (rx_tick % 5) == 0;
        endcase
    end

    // send one item, with bursts and gaps
    task automatic send_item(input logic cmd, input logic [CH_W-1:0] ch,
                             input logic [PCT_W-1:0] pct);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_channel      <= ch;
        i_duty_percent <= pct;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(pwm_timer_step(cmd, ch, pct));
        burst_left--;
    endtask

    // stop sending and let every expected item come back
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_EDGES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_period(input t_count per);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_period_ticks <= per;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_period = per;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // outputs high after reset, invalid channel flagged
    task automatic test_reset_state();
        gap_max = 0;
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '1, '1);
        send_item(CMD_DUTY, 2'd3, 8'd255);
        send_item(CMD_DUTY, 2'd3, 8'd0);
    endtask

    // percent extremes at the shortest period, match equal to period
    task automatic test_duty_extremes();
        write_period(MIN_PERIOD);
        gap_max = 2;
        send_item(CMD_DUTY, 2'd0, 8'd0);
        send_item(CMD_DUTY, 2'd1, 8'd100);
        send_item(CMD_DUTY, 2'd2, 8'd255);
        repeat (3) send_item(CMD_TICK, '0, '0);
        send_item(CMD_DUTY, 2'd0, 8'd1);
        send_item(CMD_DUTY, 2'd1, 8'd50);
        send_item(CMD_DUTY, 2'd2, 8'd49);
        repeat (3) send_item(CMD_TICK, '0, '0);
    endtask

    // longest period, then a period below the running count
    task automatic test_period_lowered();
        write_period(MAX_PERIOD);
        repeat (6) send_item(CMD_TICK, '0, '0);
        send_item(CMD_DUTY, 2'd0, 8'd99);
        send_item(CMD_DUTY, 2'd1, 8'd1);
        write_period(t_count'(3));
        repeat (2) send_item(CMD_TICK, '0, '0);
    endtask

    // random phases, each with its own period and sender pacing
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int pause_at;
        int pick;
        logic cmd;
        logic [CH_W-1:0] ch;
        logic [PCT_W-1:0] pct;
        t_count per;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                per = t_count'($urandom_range(2, 40));
            else if (pick < 16)
                per = t_count'($urandom_range(41, 400));
            else if (pick < 18)
                per = t_count'($urandom_range(401, 5000));
            else if (pick == 18)
                per = DEFAULT_PERIOD;
            else
                per = MAX_PERIOD;
            write_period(per);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 6;
            endcase
            phase_len = $urandom_range(40, 160);
            pause_at = (phase_count == 0 || $urandom_range(0, 3) == 0) ?
                       $urandom_range(1, phase_len - 1) : -1;
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (k == pause_at)
                    wait_idle();
                if ($urandom_range(0, 4) != 0) begin
                    cmd = CMD_TICK;
                    ch  = CH_W'($urandom);
                    pct = PCT_W'($urandom);
                end else begin
                    cmd = CMD_DUTY;
                    ch  = CH_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 4))
                        0:       pct = '0;
                        1:       pct = PCT_W'($urandom_range(100, 255));
                        2:       pct = PCT_W'($urandom);
                        default: pct = PCT_W'($urandom_range(1, 99));
                    endcase
                end
                send_item(cmd, ch, pct);
                sent++;
            end
            phase_count++;
        end
    endtask

    // main sequence
    initial begin
        reset_timer_model();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_duty_extremes();
        test_period_lowered();
        test_random_traffic();
        wait_idle();
        if (expected_results.size() != 0) begin
            $error("%0d expected result items never arrived", expected_results.size());
            errors++;
        end
        $display("checked %0d result items: directed duty and period corners, then %0d phases",
                 checked_count, phase_count);
        $display("of random ticks and duty writes with periods from 2 to 16777214");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
